// ===== design/fcl_pkg.sv =====
`timescale 1ns / 1ps

package fcl_pkg;

    localparam int LIST_ENTRIES_DEF = 32;

    localparam logic [7:0] NO_ERROR_CODE = 8'd99;
    localparam logic [7:0] DECIMAL_BASE  = 8'd10;
    // floor(x / 10) == (x * 205) >> 11 for every 8-bit x
    localparam logic [7:0] DIV10_MULT    = 8'd205;
    localparam int         DIV10_SHIFT   = 11;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_ROTATE  = 2'd2,
        OP_REFRESH = 2'd3
    } t_op;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic apply;
    } t_dp_cmd;

endpackage

// ===== design/fault_code_list_display_unit.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: operation; tdata: code
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser: drive, position, no-error;
//                                                    tdata: digit value, error count
//
// each item passes a capture step and an apply step: capture compares the code against
// the valid list cells in parallel and reads the display entry, apply applies the update
// and loads the result register; the result register lets a new item be taken while a
// result waits; a stalled result holds the apply step until m_axis_tready
// synchronous active-low reset; list returns to the single no-error code

module fault_code_list_display_unit #(
    parameter int LIST_ENTRIES = fcl_pkg::LIST_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] code
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] digit_value, [10:5] error_count
    output logic [2:0]  m_axis_tuser    // [0] drive, [1] digit_position, [2] no_error_symbol
);
    import fcl_pkg::*;

    t_dp_cmd    cmd;
    logic       drive;
    logic       digit_position;
    logic [4:0] digit_value;
    logic       no_error_symbol;
    logic [5:0] error_count;

    fcl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    fcl_datapath #(
        .LIST_ENTRIES (LIST_ENTRIES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_op              (s_axis_tuser),
        .i_code            (s_axis_tdata),
        .o_drive           (drive),
        .o_digit_position  (digit_position),
        .o_digit_value     (digit_value),
        .o_no_error_symbol (no_error_symbol),
        .o_error_count     (error_count)
    );

    assign m_axis_tdata = {5'b00000, error_count, digit_value};
    assign m_axis_tuser = {no_error_symbol, digit_position, drive};

endmodule

// ===== design/fcl_ctrl.sv =====
`timescale 1ns / 1ps

module fcl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output fcl_pkg::t_dp_cmd o_cmd
);
    import fcl_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.apply   = 1'b0;
        o_in_ready    = 1'b0;
        n_out_valid   = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_APPLY;
                end
            end
            S_APPLY: begin
                // hold the update until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.apply = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_no_capture_in_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> !o_cmd.capture)
        else $error("capture while an item is still pending");

    a_apply_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && !r_out_valid) |=> (r_state == S_IDLE && r_out_valid))
        else $error("apply stalled with a free output register");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result dropped");

endmodule

// ===== design/fcl_datapath.sv =====
`timescale 1ns / 1ps

module fcl_datapath #(
    parameter int LIST_ENTRIES = fcl_pkg::LIST_ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fcl_pkg::t_dp_cmd i_cmd,
    input  logic [1:0]       i_op,
    input  logic [7:0]       i_code,
    output logic             o_drive,
    output logic             o_digit_position,
    output logic [4:0]       o_digit_value,
    output logic             o_no_error_symbol,
    output logic [5:0]       o_error_count
);
    import fcl_pkg::*;

    localparam int IW = $clog2(LIST_ENTRIES);
    localparam int LW = $clog2(LIST_ENTRIES + 1);

    // list cells and display state
    logic [7:0]        r_entry [LIST_ENTRIES];
    logic [7:0]        n_entry [LIST_ENTRIES];
    logic [LW-1:0]     r_len, n_len;
    logic [IW-1:0]     r_rot, n_rot;
    logic [4:0]        r_tens, n_tens;
    logic [3:0]        r_ones, n_ones;
    logic              r_blank, n_blank;
    logic              r_phase, n_phase;

    // capture-step registers
    t_op               r_op;
    logic [7:0]        r_code;
    logic [LIST_ENTRIES-1:0] r_match, n_match;
    logic [7:0]        r_sel;
    logic [IW-1:0]     r_idx, n_idx;

    // result register
    logic              r_drive, n_drive;
    logic              r_pos, n_pos;
    logic [4:0]        r_val, n_val;
    logic              r_sym, n_sym;
    logic [5:0]        r_cnt, n_cnt;

    logic              add_ok, remove_ok, rotate_ok;
    logic [LIST_ENTRIES-1:0] shift_en;
    logic [15:0]       prod;
    logic [4:0]        quot;
    logic [7:0]        rem;
    logic [LW-1:0]     idx_inc;
    logic [LW+5:0]     len_wide;

    // capture stage: parallel compare against every valid cell, pick display entry
    always_comb begin
        for (int k = 0; k < LIST_ENTRIES; k++) begin
            n_match[k] = (LW'(k) < r_len) && (r_entry[k] == i_code);
        end
        n_idx = (LW'(r_rot) >= r_len) ? '0 : r_rot;
    end

    assign add_ok    = (r_op == OP_ADD) && (r_code != 8'd0) &&
                       (r_len < LW'(LIST_ENTRIES)) && !(|r_match);
    assign remove_ok = (r_op == OP_REMOVE) && (|r_match);
    assign rotate_ok = (r_op == OP_ROTATE) && (r_len != '0);

    // divide by ten through a reciprocal multiply
    assign prod = 16'(r_sel) * 16'(DIV10_MULT);
    assign quot = prod[DIV10_SHIFT +: 5];
    assign rem  = r_sel - ({3'b000, quot} << 3) - ({3'b000, quot} << 1);

    assign idx_inc = LW'(r_idx) + LW'(1);

    always_comb begin
        // cell k moves down when the removed entry sits at or below it
        for (int k = 0; k < LIST_ENTRIES; k++) begin
            shift_en[k] = |(r_match & ((LIST_ENTRIES'(1) << (k + 1)) - LIST_ENTRIES'(1)));
        end

        for (int k = 0; k < LIST_ENTRIES; k++) begin
            n_entry[k] = r_entry[k];
            if (add_ok && (LW'(k) == r_len)) begin
                n_entry[k] = r_code;
            end else if (remove_ok && shift_en[k]) begin
                n_entry[k] = (k + 1 < LIST_ENTRIES) ? r_entry[(k + 1) % LIST_ENTRIES] : 8'd0;
            end
        end

        n_len = r_len;
        if (add_ok) begin
            n_len = r_len + LW'(1);
        end else if (remove_ok) begin
            n_len = r_len - LW'(1);
        end

        n_rot   = r_rot;
        n_tens  = r_tens;
        n_ones  = r_ones;
        n_blank = r_blank;
        if (rotate_ok) begin
            if (r_sel == NO_ERROR_CODE) begin
                n_blank = 1'b1;
            end else begin
                n_blank = 1'b0;
                n_tens  = quot;
                n_ones  = rem[3:0];
            end
            n_rot = (idx_inc >= r_len) ? '0 : idx_inc[IW-1:0];
        end

        n_phase = r_phase;
        n_drive = 1'b0;
        n_pos   = 1'b0;
        n_val   = 5'd0;
        n_sym   = 1'b0;
        if (r_op == OP_REFRESH) begin
            n_drive = 1'b1;
            n_pos   = r_phase;
            n_sym   = r_blank;
            if (!r_blank) begin
                n_val = r_phase ? {1'b0, r_ones} : r_tens;
            end
            n_phase = ~r_phase;
        end

        len_wide = (LW + 6)'(n_len);
        n_cnt    = len_wide[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LIST_ENTRIES; k++) begin
                r_entry[k] <= (k == 0) ? NO_ERROR_CODE : 8'd0;
            end
            r_len   <= LW'(1);
            r_rot   <= '0;
            r_tens  <= '0;
            r_ones  <= '0;
            r_blank <= 1'b0;
            r_phase <= 1'b0;
            r_match <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_match <= n_match;
            end
            if (i_cmd.apply) begin
                for (int k = 0; k < LIST_ENTRIES; k++) begin
                    r_entry[k] <= n_entry[k];
                end
                r_len   <= n_len;
                r_rot   <= n_rot;
                r_tens  <= n_tens;
                r_ones  <= n_ones;
                r_blank <= n_blank;
                r_phase <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_op);
            r_code <= i_code;
            r_sel  <= r_entry[n_idx];
            r_idx  <= n_idx;
        end
        if (i_cmd.apply) begin
            r_drive <= n_drive;
            r_pos   <= n_pos;
            r_val   <= n_val;
            r_sym   <= n_sym;
            r_cnt   <= n_cnt;
        end
    end

    assign o_drive           = r_drive;
    assign o_digit_position  = r_pos;
    assign o_digit_value     = r_val;
    assign o_no_error_symbol = r_sym;
    assign o_error_count     = r_cnt;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(LIST_ENTRIES))
        else $error("list length beyond the number of cells");

    // codes in the list are unique, so a lookup hits one cell at most
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_match))
        else $error("code found in more than one cell");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && remove_ok) |=> (r_len == $past(r_len) - LW'(1)))
        else $error("remove did not shorten the list");

endmodule

// ===== verif/fault_code_list_display_unit_test.sv =====
`timescale 1ns / 1ps

module fault_code_list_display_unit_test;
    import fcl_pkg::*;

    localparam int LIST_SIZE      = LIST_ENTRIES_DEF;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        t_op         op;
        logic [7:0]  code;
        int unsigned gap;
        bit          hold;
    } t_fault_item;

    typedef struct packed {
        logic       drive;
        logic       position;
        logic [4:0] value;
        logic       blank;
        logic [5:0] count;
    } t_display_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] code
    logic [1:0]  s_axis_tuser = '0;    // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [4:0] digit_value, [10:5] error_count
    logic [2:0]  m_axis_tuser;         // [0] drive, [1] digit_position, [2] no_error_symbol

    fault_code_list_display_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0] fault_list [LIST_SIZE];
    logic [7:0] shown_tens;
    logic [7:0] shown_ones;
    logic [5:0] show_index;
    logic       digit_phase;

    t_fault_item     op_backlog [$];
    t_display_result expected_digits [$];

    int  mismatch_count = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    bit  in_fire = 1'b0;
    bit  out_fire = 1'b0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;

    task automatic flag_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic int count_entries();
        int n;
        n = 0;
        while (n < LIST_SIZE && fault_list[n] != 8'd0)
            n++;
        return n;
    endfunction

    function automatic t_display_result step_fault_list(t_op op, logic [7:0] code);
        t_display_result r;
        int              n;
        int              slot;
        bit              found;
        logic [7:0]      picked;
        logic [7:0]      digit;
        r = '0;
        n = count_entries();
        case (op)
            OP_ADD: begin
                found = 1'b0;
                for (int k = 0; k < n; k++)
                    if (fault_list[k] == code)
                        found = 1'b1;
                if (code != 8'd0 && n < LIST_SIZE && !found)
                    fault_list[n] = code;
            end
            OP_REMOVE: begin
                slot = -1;
                for (int k = 0; k < n; k++)
                    if (slot < 0 && fault_list[k] == code)
                        slot = k;
                if (slot >= 0) begin
                    for (int k = slot; k < LIST_SIZE - 1; k++)
                        fault_list[k] = fault_list[k + 1];
                    fault_list[LIST_SIZE - 1] = 8'd0;
                end
            end
            OP_ROTATE: begin
                if (n != 0) begin
                    slot = int'(show_index);
                    if (slot >= n)
                        slot = 0;
                    picked = fault_list[slot];
                    if (picked == NO_ERROR_CODE) begin
                        shown_tens = NO_ERROR_CODE;
                        shown_ones = NO_ERROR_CODE;
                    end else begin
                        shown_tens = picked / DECIMAL_BASE;
                        shown_ones = picked % DECIMAL_BASE;
                    end
                    slot++;
                    if (slot >= n)
                        slot = 0;
                    show_index = slot[5:0];
                end
            end
            default: begin
                digit = digit_phase ? shown_ones : shown_tens;
                r.drive = 1'b1;
                r.position = digit_phase;
                if (digit == NO_ERROR_CODE)
                    r.blank = 1'b1;
                else
                    r.value = digit[4:0];
                digit_phase = ~digit_phase;
            end
        endcase
        r.count = 6'(count_entries());
        return r;
    endfunction

    task automatic queue_op(t_op op, logic [7:0] code, bit hold = 1'b0);
        t_fault_item item;
        if ($urandom_range(0, 39) == 0)
            tx_calm = ~tx_calm;
        item.op = op;
        item.code = code;
        item.gap = tx_calm ? 0 : $urandom_range(0, 14);
        item.hold = hold;
        op_backlog.push_back(item);
    endtask

    // sender
    always @(negedge i_clk) begin
        t_fault_item head;
        logic        next_valid;
        next_valid = s_axis_tvalid && !in_fire;
        if (i_rst_n && !next_valid && op_backlog.size() != 0) begin
            if (op_backlog[0].gap != 0) begin
                op_backlog[0].gap = op_backlog[0].gap - 1;
            end else if (!op_backlog[0].hold || expected_digits.size() == 0) begin
                head = op_backlog.pop_front();
                s_axis_tdata <= head.code;
                s_axis_tuser <= head.op;
                next_valid = 1'b1;
            end
        end
        s_axis_tvalid <= next_valid;
    end

    // receiver: a fresh stall is drawn after every accepted item
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (out_fire) begin
                if ($urandom_range(0, 39) == 0)
                    rx_calm = ~rx_calm;
                stall_left = rx_calm ? 0 : $urandom_range(0, 14);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_display_result got;
        t_display_result want;
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_digits.push_back(step_fault_list(t_op'(s_axis_tuser), s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got.drive = m_axis_tuser[0];
                got.position = m_axis_tuser[1];
                got.blank = m_axis_tuser[2];
                got.value = m_axis_tdata[4:0];
                got.count = m_axis_tdata[10:5];
                if (expected_digits.size() == 0) begin
                    flag_mismatch("unexpected result, error_count", got.count, -1);
                end else begin
                    want = expected_digits.pop_front();
                    if (got.drive !== want.drive)
                        flag_mismatch("drive", got.drive, want.drive);
                    if (got.position !== want.position)
                        flag_mismatch("digit_position", got.position, want.position);
                    if (got.value !== want.value)
                        flag_mismatch("digit_value", got.value, want.value);
                    if (got.blank !== want.blank)
                        flag_mismatch("no_error_symbol", got.blank, want.blank);
                    if (got.count !== want.count)
                        flag_mismatch("error_count", got.count, want.count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int         mode;
        int         r;
        int         pool_base;
        logic [7:0] code;
        t_op        op;

        for (int k = 0; k < LIST_SIZE; k++)
            fault_list[k] = 8'd0;
        fault_list[0] = NO_ERROR_CODE;
        shown_tens = 8'd0;
        shown_ones = 8'd0;
        show_index = 6'd0;
        digit_phase = 1'b0;

        // directed: reset digits, blank latch, ignored adds, wide tens, empty list
        queue_op(OP_REFRESH, 8'd0);
        queue_op(OP_REFRESH, 8'd255);
        queue_op(OP_ROTATE, 8'd0);
        queue_op(OP_REFRESH, 8'd0);
        queue_op(OP_REFRESH, 8'd0);
        queue_op(OP_ADD, 8'd0);
        queue_op(OP_ADD, NO_ERROR_CODE);
        queue_op(OP_ADD, 8'd255);
        queue_op(OP_ADD, 8'd1);
        queue_op(OP_REMOVE, 8'd7);
        queue_op(OP_REMOVE, 8'd0);
        queue_op(OP_ROTATE, 8'd0);
        queue_op(OP_ROTATE, 8'd0);
        queue_op(OP_REFRESH, 8'd0);
        queue_op(OP_REFRESH, 8'd0);
        queue_op(OP_REMOVE, NO_ERROR_CODE);
        queue_op(OP_ROTATE, 8'd0);
        queue_op(OP_REMOVE, 8'd255);
        queue_op(OP_REMOVE, 8'd1);
        queue_op(OP_ROTATE, 8'd0);
        queue_op(OP_REFRESH, 8'd0);
        queue_op(OP_REFRESH, 8'd0);
        queue_op(OP_ADD, NO_ERROR_CODE);

        // fill past full with wide codes, sender holds the first add until the pipe is empty
        for (int k = 0; k < 40; k++) begin
            queue_op(OP_ADD, 8'd100 + k[7:0], k == 0);
            if (k % 6 == 5) begin
                queue_op(OP_ROTATE, 8'd0);
                queue_op(OP_REFRESH, 8'd0);
            end
        end

        // random blocks of filling, draining or mixed traffic, each block's mode drawn at random
        mode = 0;
        pool_base = 1;
        for (int k = 0; k < 840; k++) begin
            if (k % 60 == 0) begin
                mode = $urandom_range(0, 2);
                pool_base = $urandom_range(0, 1) ? 1 : 96;
            end
            r = $urandom_range(0, 9);
            case (mode)
                0:       op = (r < 6) ? OP_ADD : (r == 6) ? OP_REMOVE
                              : (r == 7) ? OP_ROTATE : OP_REFRESH;
                1:       op = (r < 2) ? OP_ADD : (r < 7) ? OP_REMOVE
                              : (r == 7) ? OP_ROTATE : OP_REFRESH;
                default: op = (r < 3) ? OP_ADD : (r < 5) ? OP_REMOVE
                              : (r < 7) ? OP_ROTATE : OP_REFRESH;
            endcase
            r = $urandom_range(0, 9);
            if (r == 0)
                code = 8'($urandom_range(0, 255));
            else if (r == 1)
                code = NO_ERROR_CODE;
            else
                code = 8'($urandom_range(pool_base, pool_base + 39));
            queue_op(op, code, $urandom_range(0, 99) == 0);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || s_axis_tvalid || expected_digits.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fcl_pkg.sv
design/fcl_ctrl.sv
design/fcl_datapath.sv
design/fault_code_list_display_unit.sv
verif/fault_code_list_display_unit_test.sv
